>>> rtl/tta_pkg.sv
// shared types and constants for the temperature to ascii digits block
// used by every module under rtl, depends on nothing else
package tta_pkg;

  localparam int RAW_W = 15;
  localparam int MAG_W = 16;
  localparam int CHAR_W = 7;
  localparam int MAX_CHARS = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MAG_W-1:0] TEMP_OFFSET = 16'd27315;
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam int RECIP_100_SHIFT = 23;
  localparam logic [7:0] RECIP_10 = 8'd205;
  localparam int RECIP_10_SHIFT = 11;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2e;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;

  typedef struct packed {
    logic       neg;
    logic [1:0] nd;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [3:0] frac_t;
    logic [3:0] frac_o;
  } tta_entry_t;

endpackage

>>> rtl/tta_front.sv
// front pipeline: offset, reciprocal divides and digit split of one reading
// depends on tta_pkg
module tta_front
  import tta_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_temp,
  output logic             out_valid,
  input  logic             out_ready,
  output tta_entry_t       out_entry
);

  logic adv;
  logic [4:0] vld_r;

  logic             s1_neg_r;
  logic [MAG_W-1:0] s1_mag_r;
  logic             s2_neg_r;
  logic [MAG_W-1:0] s2_mag_r;
  logic [8:0]       s2_q_r;
  logic             s3_neg_r;
  logic [8:0]       s3_q_r;
  logic [6:0]       s3_frac_r;
  logic [5:0]       s3_t_r;
  logic             s4_neg_r;
  logic [5:0]       s4_t_r;
  logic [3:0]       s4_ones_r;
  logic [3:0]       s4_h_r;
  logic [3:0]       s4_ft_r;
  logic [6:0]       s4_frac_r;
  tta_entry_t       s5_r;
  tta_entry_t       s5_nxt;

  logic [MAG_W-1:0] doubled;
  logic             s1_neg_nxt;
  logic [MAG_W-1:0] s1_mag_nxt;
  logic [32:0]      q_prod;
  logic [15:0]      hq;
  logic [6:0]       s3_frac_nxt;
  logic [16:0]      t_prod;
  logic [13:0]      h_prod;
  logic [14:0]      ft_prod;
  logic [8:0]       t10;
  logic [5:0]       h10;
  logic [6:0]       ft10;

  assign adv = !vld_r[4] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[4];
  assign out_entry = s5_r;

  assign doubled = {raw_temp, 1'b0};
  assign s1_neg_nxt = doubled < TEMP_OFFSET;
  assign s1_mag_nxt = s1_neg_nxt ? (TEMP_OFFSET - doubled) : (doubled - TEMP_OFFSET);

  assign q_prod = 33'(s1_mag_r) * 33'(RECIP_100);
  assign hq = 16'(s2_q_r) * 16'd100;
  assign s3_frac_nxt = 7'(s2_mag_r - hq);
  assign t_prod = 17'(s2_q_r) * 17'(RECIP_10);
  assign h_prod = 14'(s3_t_r) * 14'(RECIP_10);
  assign ft_prod = 15'(s3_frac_r) * 15'(RECIP_10);
  assign t10 = 9'(s3_t_r) * 9'd10;
  assign h10 = 6'(s4_h_r) * 6'd10;
  assign ft10 = 7'(s4_ft_r) * 7'd10;

  always_comb begin
    s5_nxt.neg = s4_neg_r;
    s5_nxt.hund = s4_h_r;
    s5_nxt.tens = 4'(s4_t_r - h10);
    s5_nxt.ones = s4_ones_r;
    s5_nxt.frac_t = s4_ft_r;
    s5_nxt.frac_o = 4'(s4_frac_r - ft10);
    if (s4_h_r != 4'd0) begin
      s5_nxt.nd = 2'd3;
    end else if (s5_nxt.tens != 4'd0) begin
      s5_nxt.nd = 2'd2;
    end else begin
      s5_nxt.nd = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r <= s1_neg_nxt;
      s1_mag_r <= s1_mag_nxt;
      s2_neg_r <= s1_neg_r;
      s2_mag_r <= s1_mag_r;
      s2_q_r <= q_prod[RECIP_100_SHIFT+8:RECIP_100_SHIFT];
      s3_neg_r <= s2_neg_r;
      s3_q_r <= s2_q_r;
      s3_frac_r <= s3_frac_nxt;
      s3_t_r <= t_prod[RECIP_10_SHIFT+5:RECIP_10_SHIFT];
      s4_neg_r <= s3_neg_r;
      s4_t_r <= s3_t_r;
      s4_ones_r <= 4'(s3_q_r - t10);
      s4_h_r <= 4'(h_prod[13:RECIP_10_SHIFT]);
      s4_ft_r <= ft_prod[RECIP_10_SHIFT+3:RECIP_10_SHIFT];
      s4_frac_r <= s3_frac_r;
      s5_r <= s5_nxt;
    end
  end

endmodule

>>> rtl/tta_queue.sv
// short queue of digit entries between the front pipeline and the serializer
// depends on tta_pkg
module tta_queue
  import tta_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  tta_entry_t wr_entry,
  output logic       rd_valid,
  input  logic       rd_ready,
  output tta_entry_t rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tta_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign wr_ready = cnt_r != FULL_CNT;
  assign rd_valid = cnt_r != '0;
  assign rd_entry = mem_r[rptr_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

endmodule

>>> rtl/tta_back.sv
// serializer: turns one digit entry into ascii words, one per cycle while the output is not stalled
// depends on tta_pkg
module tta_back
  import tta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  tta_entry_t        q_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_code,
  output logic              last_char
);

  logic              cur_valid_r;
  tta_entry_t        cur_r;
  logic [2:0]        idx_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  logic [CHAR_W-1:0] seq [MAX_CHARS];
  logic [2:0]        cnt;
  logic              out_ok;
  logic              emit;
  logic              is_last;

  always_comb begin
    logic [2:0] p;
    p = 3'd0;
    for (int k = 0; k < MAX_CHARS; k++) begin
      seq[k] = ASCII_ZERO;
    end
    if (cur_r.neg) begin
      seq[p] = ASCII_MINUS;
      p = p + 3'd1;
    end
    if (cur_r.nd == 2'd3) begin
      seq[p] = ASCII_ZERO | {3'b000, cur_r.hund};
      p = p + 3'd1;
    end
    if (cur_r.nd != 2'd1) begin
      seq[p] = ASCII_ZERO | {3'b000, cur_r.tens};
      p = p + 3'd1;
    end
    seq[p] = ASCII_ZERO | {3'b000, cur_r.ones};
    p = p + 3'd1;
    seq[p] = ASCII_POINT;
    p = p + 3'd1;
    seq[p] = ASCII_ZERO | {3'b000, cur_r.frac_t};
    p = p + 3'd1;
    if (cur_r.neg) begin
      seq[p] = ASCII_ZERO | {3'b000, cur_r.frac_o};
      p = p + 3'd1;
    end
    cnt = p;
  end

  assign out_ok = !out_valid_r || out_ready;
  assign emit = cur_valid_r && out_ok;
  assign is_last = idx_r == (cnt - 3'd1);
  assign q_ready = !cur_valid_r || (emit && is_last);

  assign out_valid = out_valid_r;
  assign char_code = char_r;
  assign last_char = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_ready) begin
        cur_valid_r <= q_valid;
        idx_r <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      cur_r <= q_entry;
    end
    if (emit) begin
      char_r <= seq[idx_r];
      last_r <= is_last;
    end
  end

endmodule

>>> rtl/temperature_to_ascii_digits.sv
// top level: sensor reading in, ascii characters of the celsius value out
// depends on tta_pkg, tta_front, tta_queue and tta_back
//
// usage
//   in_*  : one word per reading, in_tdata[14:0] is the raw value, 0.02 K per lsb
//   out_* : one word per character in display order, out_tlast on the last one
//   a reading gives 3 to 7 characters, e.g. "25.3" or "-12.45"
// path: the first of 5 front stages loads at the accepting edge, then the
//   reading passes 4 more front stages, the queue write, the serializer load
//   and the output register before its first character is presented
// throughput: one character per cycle on the output while out_tready is high;
//   the serializer loads the next reading in the cycle that sends the last
//   character, so characters of successive readings follow without gaps while
//   the queue holds the next one; the front accepts one reading per cycle until
//   the queue is full and its last stage holds a reading
// reset: synchronous, active low; pipeline, queue and output are emptied
// stall: when out_tready is low the output word holds, the serializer waits,
//   the queue fills and then in_tready drops
module temperature_to_ascii_digits
  import tta_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [15:0] in_tdata,   // raw_temp[14:0], zero pad
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // char_code[6:0], zero pad
  output logic       out_tlast
);

  logic       f_valid, f_ready;
  tta_entry_t f_entry;
  logic       q_valid, q_ready;
  tta_entry_t q_entry;
  logic [CHAR_W-1:0] char_code;

  tta_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .raw_temp  (in_tdata[RAW_W-1:0]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_entry (f_entry)
  );

  tta_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_entry (f_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  tta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .char_code (char_code),
    .last_char (out_tlast)
  );

  assign out_tdata = {1'b0, char_code};

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for temperature_to_ascii_digits: corner readings, then
// random readings under several idle and stall mixes, checked one character at a time
// depends on tta_pkg and the rtl of the block
module testbench
  import tta_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP = 24;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_word_t;

  class char_scoreboard;
    char_word_t expected_q[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void push_char(logic [CHAR_W-1:0] code);
      char_word_t w;
      w.code = code;
      w.last = 1'b0;
      expected_q.push_back(w);
    endfunction

    function void push_whole(int unsigned whole);
      if (whole >= 100) begin
        push_char(ASCII_ZERO + CHAR_W'((whole / 100) % 10));
        push_char(ASCII_ZERO + CHAR_W'((whole % 100) / 10));
        push_char(ASCII_ZERO + CHAR_W'(whole % 10));
      end else if (whole >= 10) begin
        push_char(ASCII_ZERO + CHAR_W'(whole / 10));
        push_char(ASCII_ZERO + CHAR_W'(whole % 10));
      end else begin
        push_char(ASCII_ZERO + CHAR_W'(whole));
      end
    endfunction

    // expected characters of one accepted reading, in display order
    function void note_reading(logic [RAW_W-1:0] raw);
      int unsigned hundredths;
      int unsigned mag;
      int unsigned frac;
      hundredths = 32'(raw) * 2;
      if (hundredths >= 32'(TEMP_OFFSET)) begin
        mag = hundredths - 32'(TEMP_OFFSET);
        frac = mag % 100;
        push_whole(mag / 100);
        push_char(ASCII_POINT);
        push_char(ASCII_ZERO + CHAR_W'(frac / 10));
      end else begin
        mag = 32'(TEMP_OFFSET) - hundredths;
        frac = mag % 100;
        push_char(ASCII_MINUS);
        push_whole(mag / 100);
        push_char(ASCII_POINT);
        push_char(ASCII_ZERO + CHAR_W'(frac / 10));
        push_char(ASCII_ZERO + CHAR_W'(frac % 10));
      end
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      char_word_t w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected char %h last %b", code, last);
        return;
      end
      w = expected_q.pop_front();
      if (code !== w.code || last !== w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected char %h last %b, got char %h last %b",
                   w.code, w.last, code, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // raw_temp[14:0], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // char_code[6:0], zero pad
  logic        out_tlast;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  char_scoreboard sb = new();

  logic [RAW_W-1:0] corner_readings [22] = '{
    15'd0, 15'd1, 15'd32767, 15'd16384, 15'd21845, 15'd10922,
    15'd13657, 15'd13658, 15'd13650, 15'd13662, 15'd14157, 15'd14158,
    15'd18657, 15'd18658, 15'd8658, 15'd8657, 15'd13608, 15'd13607,
    15'd13163, 15'd13162, 15'd17000, 15'd4096
  };

  temperature_to_ascii_digits uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_reading(in_tdata[RAW_W-1:0]);
      if (out_tvalid && out_tready)
        sb.check_char(out_tdata[CHAR_W-1:0], out_tlast);
    end
  end

  // mix of full range, near zero celsius and near the hundreds boundaries
  function automatic logic [RAW_W-1:0] random_reading();
    case ($urandom_range(3))
      0, 1: return RAW_W'($urandom_range(32767));
      2: return RAW_W'($urandom_range(14700, 12600));
      default: begin
        if ($urandom_range(1))
          return RAW_W'($urandom_range(8720, 8600));
        else
          return RAW_W'($urandom_range(18720, 18600));
      end
    endcase
  endfunction

  task automatic send_reading(input logic [RAW_W-1:0] raw);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      send_reading(random_reading());
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_readings[i])
      send_reading(corner_readings[i]);

    run_phase(0, 0);
    run_phase(76, 0);
    run_phase(0, 76);
    run_phase(9, 9);

    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
